@@ design/olt_pkg.sv @@
package olt_pkg;

    localparam logic [1:0] OP_OCCUPY = 2'd0;
    localparam logic [1:0] OP_UNLOCK = 2'd1;
    localparam logic [1:0] OP_ABORT_DONE = 2'd2;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_DENIED = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_ABSENT = 2'd3;

    localparam int ID_BITS = 32;
    localparam int DYN_BITS = 8;
    localparam int IN_KEY_BITS = 32;

endpackage

@@ design/olt_if.sv @@
interface olt_req_if;
    logic                             valid;
    logic                             ready;
    logic [1:0]                       opcode;
    logic [olt_pkg::IN_KEY_BITS-1:0]  lock_key;
    logic [olt_pkg::ID_BITS-1:0]      requester_id;
    logic [olt_pkg::DYN_BITS-1:0]     requester_dyn_id;

    modport source (output valid, opcode, lock_key, requester_id, requester_dyn_id,
                    input ready);
    modport sink (input valid, opcode, lock_key, requester_id, requester_dyn_id,
                  output ready);
endinterface

interface olt_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         granted;
    logic [olt_pkg::ID_BITS-1:0]  holder_id;
    logic                         must_wait;
    logic [olt_pkg::DYN_BITS-1:0] wait_on_dyn_id;
    logic                         released;
    logic [1:0]                   status;

    modport source (output valid, granted, holder_id, must_wait, wait_on_dyn_id,
                    released, status, input ready);
    modport sink (input valid, granted, holder_id, must_wait, wait_on_dyn_id,
                  released, status, output ready);
endinterface

@@ design/olt_front.sv @@
module olt_front #(
    parameter int KEY_BITS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    olt_req_if.sink                       req,
    input  logic                          clearing,
    output logic                          q_valid,
    input  logic                          q_pop,
    output logic [1:0]                    q_op,
    output logic [KEY_BITS-1:0]           q_key,
    output logic [olt_pkg::ID_BITS-1:0]   q_id,
    output logic [olt_pkg::DYN_BITS-1:0]  q_dyn
);

    typedef struct packed {
        logic [1:0]                   op;
        logic [KEY_BITS-1:0]          key;
        logic [olt_pkg::ID_BITS-1:0]  id;
        logic [olt_pkg::DYN_BITS-1:0] dyn;
    } word_t;

    word_t      slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push;
    word_t      in_word;

    assign req.ready = (cnt_reg != 2'd2) && !clearing;
    assign push = req.valid && req.ready;
    assign q_valid = (cnt_reg != 2'd0);

    always_comb
    begin
        in_word.op = req.opcode;
        in_word.key = KEY_BITS'(req.lock_key);
        in_word.id = req.requester_id;
        in_word.dyn = req.requester_dyn_id;
    end

    assign q_op = slot_reg[rd_ptr_reg].op;
    assign q_key = slot_reg[rd_ptr_reg].key;
    assign q_id = slot_reg[rd_ptr_reg].id;
    assign q_dyn = slot_reg[rd_ptr_reg].dyn;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(q_pop);
        end
    end

endmodule

@@ design/olt_back.sv @@
module olt_back #(
    parameter int TABLE_ENTRIES = 64,
    parameter int KEY_BITS = 32,
    parameter int DYN_ID_COUNT = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    output logic                          clearing,
    input  logic                          q_valid,
    output logic                          q_pop,
    input  logic [1:0]                    q_op,
    input  logic [KEY_BITS-1:0]           q_key,
    input  logic [olt_pkg::ID_BITS-1:0]   q_id,
    input  logic [olt_pkg::DYN_BITS-1:0]  q_dyn,
    olt_rsp_if.source                     rsp
);

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int DW = (DYN_ID_COUNT > 1) ? $clog2(DYN_ID_COUNT) : 1;

    typedef struct packed {
        logic [KEY_BITS-1:0]          key;
        logic                         occ;
        logic [olt_pkg::ID_BITS-1:0]  owner;
        logic [olt_pkg::DYN_BITS-1:0] dyn;
    } entry_t;

    typedef enum logic [2:0] {CLEAR, IDLE, SCAN, HIT, MISS, ABCHK} state_t;

    function automatic logic [DW-1:0] dyn_index(input logic [olt_pkg::DYN_BITS-1:0] v);
        logic [31:0] r;
        logic [31:0] s;
        r = 32'(v);
        for (int k = 7; k >= 0; k--)
        begin
            s = 32'(DYN_ID_COUNT) << k;
            if (r >= s)
            begin
                r = r - s;
            end
        end
        return r[DW-1:0];
    endfunction

    entry_t mem [TABLE_ENTRIES];
    logic   ab_mem [DYN_ID_COUNT];

    state_t state_reg, state_next;
    logic [1:0]                   op_reg, op_next;
    logic [KEY_BITS-1:0]          key_reg, key_next;
    logic [olt_pkg::ID_BITS-1:0]  id_reg, id_next;
    logic [olt_pkg::DYN_BITS-1:0] dyn_reg, dyn_next;
    logic [DW-1:0]                dix_reg, dix_next;
    logic [AW:0]                  fill_reg, fill_next;
    logic [AW:0]                  scan_reg, scan_next;
    logic [AW-1:0]                rd_idx_reg, rd_idx_next;
    logic [AW-1:0]                hit_reg, hit_next;
    logic                         rd_vld_reg, rd_vld_next;
    logic [DW:0]                  clr_reg, clr_next;

    entry_t rd_reg;
    logic   ab_rd_reg;

    logic                         res_vld_reg;
    logic                         res_set;
    logic                         r_granted, r_must_wait, r_released;
    logic [olt_pkg::ID_BITS-1:0]  r_holder;
    logic [olt_pkg::DYN_BITS-1:0] r_wait_on;
    logic [1:0]                   r_status;
    logic                         granted_reg, must_wait_reg, released_reg;
    logic [olt_pkg::ID_BITS-1:0]  holder_reg;
    logic [olt_pkg::DYN_BITS-1:0] wait_on_reg;
    logic [1:0]                   status_reg;

    logic          mem_we, rd_en, ab_we, ab_re;
    logic [AW-1:0] mem_wa, rd_a;
    entry_t        mem_wd, take;
    logic [DW-1:0] ab_wa, ab_ra;
    logic          ab_wd;
    logic          match, issuing;

    assign clearing = (state_reg == CLEAR);
    assign match = rd_vld_reg && (rd_reg.key == key_reg);

    always_comb
    begin
        take.key = key_reg;
        take.occ = 1'b1;
        take.owner = id_reg;
        take.dyn = dyn_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg;
        key_next = key_reg;
        id_next = id_reg;
        dyn_next = dyn_reg;
        dix_next = dix_reg;
        fill_next = fill_reg;
        scan_next = scan_reg;
        rd_idx_next = rd_idx_reg;
        hit_next = hit_reg;
        rd_vld_next = 1'b0;
        clr_next = clr_reg;
        q_pop = 1'b0;
        mem_we = 1'b0;
        mem_wa = hit_reg;
        mem_wd = take;
        rd_en = 1'b0;
        rd_a = scan_reg[AW-1:0];
        ab_we = 1'b0;
        ab_wa = dix_reg;
        ab_wd = 1'b0;
        ab_re = 1'b0;
        ab_ra = dyn_index(rd_reg.dyn);
        issuing = 1'b0;
        res_set = 1'b0;
        r_granted = 1'b0;
        r_holder = '0;
        r_must_wait = 1'b0;
        r_wait_on = '0;
        r_released = 1'b0;
        r_status = olt_pkg::ST_OK;
        case (state_reg)
            CLEAR:
            begin
                ab_we = 1'b1;
                ab_wa = clr_reg[DW-1:0];
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (DW+1)'(DYN_ID_COUNT - 1))
                begin
                    state_next = IDLE;
                end
            end
            IDLE:
            begin
                if (q_valid && (!res_vld_reg || rsp.ready))
                begin
                    q_pop = 1'b1;
                    op_next = q_op;
                    key_next = q_key;
                    id_next = q_id;
                    dyn_next = q_dyn;
                    dix_next = dyn_index(q_dyn);
                    case (q_op)
                        olt_pkg::OP_OCCUPY, olt_pkg::OP_UNLOCK:
                        begin
                            scan_next = '0;
                            state_next = SCAN;
                        end
                        olt_pkg::OP_ABORT_DONE:
                        begin
                            ab_we = 1'b1;
                            ab_wa = dyn_index(q_dyn);
                            res_set = 1'b1;
                            r_released = 1'b1;
                        end
                        default:
                        begin
                            res_set = 1'b1;
                        end
                    endcase
                end
            end
            SCAN:
            begin
                issuing = !match && (scan_reg < fill_reg);
                rd_en = issuing;
                rd_vld_next = issuing;
                if (issuing)
                begin
                    rd_idx_next = scan_reg[AW-1:0];
                    scan_next = scan_reg + 1'b1;
                end
                if (match)
                begin
                    hit_next = rd_idx_reg;
                    state_next = HIT;
                end
                else if (!issuing && !rd_vld_reg)
                begin
                    state_next = MISS;
                end
            end
            HIT:
            begin
                if (op_reg == olt_pkg::OP_UNLOCK)
                begin
                    mem_wd = rd_reg;
                    mem_wd.occ = 1'b0;
                    mem_we = (rd_reg.owner == id_reg);
                    res_set = 1'b1;
                    state_next = IDLE;
                end
                else if (!rd_reg.occ)
                begin
                    mem_we = 1'b1;
                    res_set = 1'b1;
                    r_granted = 1'b1;
                    state_next = IDLE;
                end
                else
                begin
                    ab_re = 1'b1;
                    state_next = ABCHK;
                end
            end
            ABCHK:
            begin
                res_set = 1'b1;
                state_next = IDLE;
                if (!ab_rd_reg)
                begin
                    ab_we = 1'b1;
                    ab_wd = 1'b1;
                    r_holder = rd_reg.owner;
                    r_status = olt_pkg::ST_DENIED;
                end
                else
                begin
                    mem_we = 1'b1;
                    r_granted = 1'b1;
                    r_must_wait = 1'b1;
                    r_wait_on = rd_reg.dyn;
                end
            end
            MISS:
            begin
                res_set = 1'b1;
                state_next = IDLE;
                if (op_reg == olt_pkg::OP_UNLOCK)
                begin
                    r_status = olt_pkg::ST_ABSENT;
                end
                else if (fill_reg < (AW+1)'(TABLE_ENTRIES))
                begin
                    mem_we = 1'b1;
                    mem_wa = fill_reg[AW-1:0];
                    fill_next = fill_reg + 1'b1;
                    r_granted = 1'b1;
                end
                else
                begin
                    r_status = olt_pkg::ST_FULL;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (rd_en)
        begin
            rd_reg <= mem[rd_a];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ab_we)
        begin
            ab_mem[ab_wa] <= ab_wd;
        end
        if (ab_re)
        begin
            ab_rd_reg <= ab_mem[ab_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        key_reg <= key_next;
        id_reg <= id_next;
        dyn_reg <= dyn_next;
        dix_reg <= dix_next;
        scan_reg <= scan_next;
        rd_idx_reg <= rd_idx_next;
        hit_reg <= hit_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CLEAR;
            fill_reg <= '0;
            rd_vld_reg <= 1'b0;
            clr_reg <= '0;
            res_vld_reg <= 1'b0;
            granted_reg <= 1'b0;
            holder_reg <= '0;
            must_wait_reg <= 1'b0;
            wait_on_reg <= '0;
            released_reg <= 1'b0;
            status_reg <= olt_pkg::ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg <= fill_next;
            rd_vld_reg <= rd_vld_next;
            clr_reg <= clr_next;
            if (res_set)
            begin
                res_vld_reg <= 1'b1;
                granted_reg <= r_granted;
                holder_reg <= r_holder;
                must_wait_reg <= r_must_wait;
                wait_on_reg <= r_wait_on;
                released_reg <= r_released;
                status_reg <= r_status;
            end
            else if (rsp.ready)
            begin
                res_vld_reg <= 1'b0;
            end
        end
    end

    assign rsp.valid = res_vld_reg;
    assign rsp.granted = granted_reg;
    assign rsp.holder_id = holder_reg;
    assign rsp.must_wait = must_wait_reg;
    assign rsp.wait_on_dyn_id = wait_on_reg;
    assign rsp.released = released_reg;
    assign rsp.status = status_reg;

endmodule

@@ design/occupy_lock_table_top.sv @@
// Lock table with abort marking. Requests enter on req, one response word per
// request leaves on rsp. Occupy and unlock search the table one entry per cycle
// through a registered memory read, up to fill entries, where fill is the number
// of keys allocated so far (up to TABLE_ENTRIES, 64 at the defaults); an occupy
// that finds the key held also looks up the aborting set. Abort-finish and
// unused opcodes are answered from the idle state without a search. A two-word
// queue in front lets new requests enter while one is in progress.
// After reset the aborting set is cleared one entry a cycle, all DYN_ID_COUNT
// entries, and req stays not ready until that pass is done.
module occupy_lock_table_top #(
    parameter int TABLE_ENTRIES = 64,
    parameter int KEY_BITS = 32,
    parameter int DYN_ID_COUNT = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    olt_req_if.sink    req,
    olt_rsp_if.source  rsp
);

    logic                         clearing;
    logic                         q_valid, q_pop;
    logic [1:0]                   q_op;
    logic [KEY_BITS-1:0]          q_key;
    logic [olt_pkg::ID_BITS-1:0]  q_id;
    logic [olt_pkg::DYN_BITS-1:0] q_dyn;

    olt_front #(
        .KEY_BITS (KEY_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .clearing (clearing),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_op     (q_op),
        .q_key    (q_key),
        .q_id     (q_id),
        .q_dyn    (q_dyn)
    );

    olt_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .KEY_BITS      (KEY_BITS),
        .DYN_ID_COUNT  (DYN_ID_COUNT)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .clearing (clearing),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_op     (q_op),
        .q_key    (q_key),
        .q_id     (q_id),
        .q_dyn    (q_dyn),
        .rsp      (rsp)
    );

endmodule
